// File: src/barometer_pressure_compensation_top_defines.svh
// Assertion macros for the barometer compensation RTL
`ifndef BAROMETER_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETER_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define BPC_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("bpc assertion failed");

// condition holds in the cycle after the trigger
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("bpc assertion failed");

`endif

// File: src/bpc_pkg.sv
// Package: types, register indexes and helpers of the pressure compensation block
package bpc_pkg;

	localparam int DIV_W  = 32;
	localparam int SIDE_W = 53;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

	localparam logic [1:0] OSS_RESET = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  den;
		logic [SIDE_W-1:0] side;
	} div_req_t;

	typedef struct packed {
		logic              valid;
		logic [DIV_W-1:0]  quo;
		logic [SIDE_W-1:0] side;
	} div_rsp_t;

	// signed division by 2^k, truncating toward zero
	function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
		logic [31:0] bias;
		bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		return 32'($signed(a + bias) >>> k);
	endfunction

	// 16-bit sign extension
	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// File: src/barometer_pressure_compensation_top.sv
// Top level: pipelined barometer temperature and pressure compensation
//
// Input channel in_valid/in_ready carries raw_temperature and raw_pressure.
// Output channel out_valid/out_ready returns temperature_tenths (0.1 degC),
// pressure_pa and status (1 when a divisor was zero; both values then 0).
// Configuration channel cfg_valid/cfg_ready writes cfg_data to register
// cfg_index: 0 AC1/AC2, 1 AC3/AC4, 2 AC5/AC6, 3 B1/B2, 4 MC/MD, 5 oversampling.
// cfg_ready is always high; writes beyond index 5 are ignored.
// Throughput is one item per cycle while the output is not stalled. The pipeline
// has 19 arithmetic stages plus two 32-stage pipelined dividers.
// All stages advance together whenever the output register is empty or is
// being taken; while the receiver stalls, the whole pipeline holds and
// in_ready is low, so nothing is lost or repeated.
// Reset clears all valid bits, the calibration registers to 0 and the
// oversampling setting to 3.
module barometer_pressure_compensation_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      raw_temperature,
	input  logic [18:0]                      raw_pressure,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [15:0]               temperature_tenths,
	output logic [19:0]                      pressure_pa,
	output logic                             status,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);

	`include "barometer_pressure_compensation_top_defines.svh"

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;
	logic        en;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= bpc_pkg::OSS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bpc_pkg::REG_AC1_AC2: ac12_q <= cfg_data;
				bpc_pkg::REG_AC3_AC4: ac34_q <= cfg_data;
				bpc_pkg::REG_AC5_AC6: ac56_q <= cfg_data;
				bpc_pkg::REG_B1_B2:   b12_q  <= cfg_data;
				bpc_pkg::REG_MC_MD:   mcmd_q <= cfg_data;
				bpc_pkg::REG_OSS:     oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// coefficients widened to 32-bit words
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = bpc_pkg::sext16(ac12_q[31:16]);
	assign ac2 = bpc_pkg::sext16(ac12_q[15:0]);
	assign ac3 = bpc_pkg::sext16(ac34_q[31:16]);
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = bpc_pkg::sext16(b12_q[31:16]);
	assign b2  = bpc_pkg::sext16(b12_q[15:0]);
	assign mc  = bpc_pkg::sext16(mcmd_q[31:16]);
	assign md  = bpc_pkg::sext16(mcmd_q[15:0]);

	logic out_valid_q;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// pipeline registers
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic        v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;
	logic [31:0] m1_s1, x1_s2, den_s2, b5_s4, t_s5, b6_s5;
	logic [18:0] up_s1, up_s2, up_s4, up_s5, up_s6, up_s7, up_s8, up_s9, up_s10;
	logic        z_s4, z_s5, z_s6, z_s7, z_s8, z_s9, z_s10, z_s11, z_s12, z_s14, z_s15;
	logic        z_s16, z_s17, z_s18;
	logic [15:0] t16_s6, t16_s7, t16_s8, t16_s9, t16_s10, t16_s11, t16_s12, t16_s14;
	logic [15:0] t16_s15, t16_s16, t16_s17, t16_s18;
	logic [31:0] sqp_s6, a2p_s6, a3p_s6, sq_s7, x2a_s7, x1c_s7;
	logic [31:0] b2sq_s8, b1sq_s8, x2a_s8, x1c_s8;
	logic [31:0] b3a_s9, s3_s9, b3_s10, y_s10, b4p_s11, d7_s11, b4_s12, b7_s12;
	logic [31:0] p_s14, qq_s15, mp_s15, p_s15, x1m_s16, x2_s16, p_s16;
	logic [31:0] sum_s17, p_s17, p_s18;
	logic [31:0] num_s3, dvr_s3, num_s13, dvr_s13;
	logic [bpc_pkg::SIDE_W-1:0] side_s3, side_s13;
	bpc_pkg::div_req_t req_s3, req_s13;
	bpc_pkg::div_rsp_t rsp1, rsp2;

	// divider requests assembled from their stage registers
	assign req_s3  = {v_s3, num_s3, dvr_s3, side_s3};
	assign req_s13 = {v_s13, num_s13, dvr_s13, side_s13};

	// first divider: x2 = MC * 2048 / (X1 + MD)
	bpc_div u_div_t (.clk(clk), .arst_n(arst_n), .en(en), .req(req_s3), .rsp(rsp1));
	// second divider: pressure quotient by B4
	bpc_div u_div_p (.clk(clk), .arst_n(arst_n), .en(en), .req(req_s13), .rsp(rsp2));

	// stage combinational terms
	logic [31:0] mcn, nmag, dmag, x2_4, b5_4, t_6, q_15, p_19;
	logic [31:0] b7_13, c50k;
	assign mcn  = {mc[20:0], 11'd0};
	assign nmag = mcn[31] ? (32'd0 - mcn) : mcn;
	assign dmag = den_s2[31] ? (32'd0 - den_s2) : den_s2;
	assign x2_4 = rsp1.side[0] ? (32'd0 - rsp1.quo) : rsp1.quo;
	assign b5_4 = rsp1.side[52:21] + x2_4;
	assign t_6  = t_s5;
	assign q_15 = bpc_pkg::sdiv_pow2(p_s14, 5'd8);
	assign b7_13 = b7_s12;
	assign c50k = 32'd50000 >> oss_q;
	assign p_19 = p_s18;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
			{v_s13, v_s14, v_s15, v_s16, v_s17, v_s18} <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= rsp1.valid;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= v_s9;
			v_s11       <= v_s10;
			v_s12       <= v_s11;
			v_s13       <= v_s12;
			v_s14       <= rsp2.valid;
			v_s15       <= v_s14;
			v_s16       <= v_s15;
			v_s17       <= v_s16;
			v_s18       <= v_s17;
			out_valid_q <= v_s18;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			// S1: (UT - AC6) * AC5
			m1_s1 <= ({16'd0, raw_temperature} - ac6) * ac5;
			up_s1 <= raw_pressure;
			// S2: X1 and temperature divisor
			x1_s2  <= bpc_pkg::sdiv_pow2(m1_s1, 5'd15);
			den_s2 <= bpc_pkg::sdiv_pow2(m1_s1, 5'd15) + md;
			up_s2  <= up_s1;
			// S3: magnitudes into the divider
			num_s3  <= nmag;
			dvr_s3  <= dmag;
			side_s3 <= {x1_s2, up_s2, den_s2 == 32'd0, mcn[31] ^ den_s2[31]};
			// S4: B5
			b5_s4 <= b5_4;
			up_s4 <= rsp1.side[20:2];
			z_s4  <= rsp1.side[1];
			// S5: temperature and B6
			t_s5  <= bpc_pkg::sdiv_pow2(b5_s4 + 32'd8, 5'd4);
			b6_s5 <= b5_s4 - 32'd4000;
			up_s5 <= up_s4;
			z_s5  <= z_s4;
			// S6: temperature saturation, products of B6
			if ($signed(t_6) < -32'sd32768)    t16_s6 <= 16'h8000;
			else if ($signed(t_6) > 32'sd32767) t16_s6 <= 16'h7fff;
			else                                t16_s6 <= t_6[15:0];
			sqp_s6 <= b6_s5 * b6_s5;
			a2p_s6 <= ac2 * b6_s5;
			a3p_s6 <= ac3 * b6_s5;
			up_s6  <= up_s5;
			z_s6   <= z_s5;
			// S7: scaled terms
			sq_s7   <= bpc_pkg::sdiv_pow2(sqp_s6, 5'd12);
			x2a_s7  <= bpc_pkg::sdiv_pow2(a2p_s6, 5'd11);
			x1c_s7  <= bpc_pkg::sdiv_pow2(a3p_s6, 5'd13);
			up_s7   <= up_s6;
			z_s7    <= z_s6;
			t16_s7  <= t16_s6;
			// S8: B2 and B1 products
			b2sq_s8 <= b2 * sq_s7;
			b1sq_s8 <= b1 * sq_s7;
			x2a_s8  <= x2a_s7;
			x1c_s8  <= x1c_s7;
			up_s8   <= up_s7;
			z_s8    <= z_s7;
			t16_s8  <= t16_s7;
			// S9: sums ahead of B3 and B4
			b3a_s9 <= {ac1[29:0], 2'b00} + bpc_pkg::sdiv_pow2(b2sq_s8, 5'd11) + x2a_s8;
			s3_s9  <= x1c_s8 + bpc_pkg::sdiv_pow2(b1sq_s8, 5'd16) + 32'd2;
			up_s9  <= up_s8;
			z_s9   <= z_s8;
			t16_s9 <= t16_s8;
			// S10: B3 and X3 + 32768
			b3_s10  <= bpc_pkg::sdiv_pow2((b3a_s9 << oss_q) + 32'd2, 5'd2);
			y_s10   <= bpc_pkg::sdiv_pow2(s3_s9, 5'd2) + 32'd32768;
			up_s10  <= up_s9;
			z_s10   <= z_s9;
			t16_s10 <= t16_s9;
			// S11: B4 product and UP - B3
			b4p_s11 <= ac4 * y_s10;
			d7_s11  <= {13'd0, up_s10} - b3_s10;
			z_s11   <= z_s10;
			t16_s11 <= t16_s10;
			// S12: B4 and B7
			b4_s12  <= b4p_s11 >> 15;
			b7_s12  <= d7_s11 * c50k;
			z_s12   <= z_s11;
			t16_s12 <= t16_s11;
			// S13: into the pressure divider
			num_s13  <= b7_13[31] ? b7_13 : {b7_13[30:0], 1'b0};
			dvr_s13  <= b4_s12;
			side_s13 <= {35'd0, t16_s12, z_s12 | (b4_s12 == 32'd0), b7_13[31]};
			// S14: pressure before correction
			p_s14   <= rsp2.side[0] ? {rsp2.quo[30:0], 1'b0} : rsp2.quo;
			z_s14   <= rsp2.side[1];
			t16_s14 <= rsp2.side[17:2];
			// S15: correction products
			qq_s15  <= q_15 * q_15;
			mp_s15  <= (32'd0 - 32'd7357) * p_s14;
			p_s15   <= p_s14;
			z_s15   <= z_s14;
			t16_s15 <= t16_s14;
			// S16
			x1m_s16 <= qq_s15 * 32'd3038;
			x2_s16  <= bpc_pkg::sdiv_pow2(mp_s15, 5'd16);
			p_s16   <= p_s15;
			z_s16   <= z_s15;
			t16_s16 <= t16_s15;
			// S17
			sum_s17 <= bpc_pkg::sdiv_pow2(x1m_s16, 5'd16) + x2_s16 + 32'd3791;
			p_s17   <= p_s16;
			z_s17   <= z_s16;
			t16_s17 <= t16_s16;
			// S18: corrected pressure
			p_s18   <= p_s17 + bpc_pkg::sdiv_pow2(sum_s17, 5'd4);
			z_s18   <= z_s17;
			t16_s18 <= t16_s17;
			// output register with pressure saturation
			status <= z_s18;
			if (z_s18) begin
				temperature_tenths <= '0;
				pressure_pa        <= '0;
			end else begin
				temperature_tenths <= t16_s18;
				if (p_19[31])                    pressure_pa <= '0;
				else if (p_19 > 32'd1048575)     pressure_pa <= 20'hfffff;
				else                             pressure_pa <= p_19[19:0];
			end
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`BPC_ASSERT_SAME(a_status_zero, clk, arst_n, out_valid && status,
		temperature_tenths == 16'sd0 && pressure_pa == 20'd0)
	`BPC_ASSERT_SAME(a_ready_low_only_on_wait, clk, arst_n, !in_ready, out_valid && !out_ready)
	`BPC_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !in_ready, $stable(p_s18) && $stable(v_s18))

endmodule

// File: src/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage
module bpc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  bpc_pkg::div_req_t req,
	output bpc_pkg::div_rsp_t rsp
);

	localparam int N = bpc_pkg::DIV_W;

	logic [N-1:0]              rem_s  [N];
	logic [N-1:0]              num_s  [N];
	logic [N-1:0]              den_s  [N];
	logic [N-1:0]              quo_s  [N];
	logic [bpc_pkg::SIDE_W-1:0] side_s [N];
	logic                      vld_s  [N];

	logic [N-1:0] rem_nx [N];
	logic [N-1:0] num_nx [N];
	logic [N-1:0] quo_nx [N];

	// one shift, compare and subtract per stage
	always_comb begin
		logic [N-1:0] rem_p;
		logic [N-1:0] num_p;
		logic [N-1:0] den_p;
		logic [N-1:0] quo_p;
		logic [N+1:0] trial;
		logic [N+1:0] diff;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				rem_p = '0;
				num_p = req.num;
				den_p = req.den;
				quo_p = '0;
			end else begin
				rem_p = rem_s[k-1];
				num_p = num_s[k-1];
				den_p = den_s[k-1];
				quo_p = quo_s[k-1];
			end
			trial = {1'b0, rem_p, num_p[N-1]};
			diff  = trial - {2'b00, den_p};
			if (!diff[N+1]) begin
				rem_nx[k] = diff[N-1:0];
				quo_nx[k] = {quo_p[N-2:0], 1'b1};
			end else begin
				rem_nx[k] = trial[N-1:0];
				quo_nx[k] = {quo_p[N-2:0], 1'b0};
			end
			num_nx[k] = {num_p[N-2:0], 1'b0};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= req.valid;
			for (int k = 1; k < N; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_nx[k];
				num_s[k] <= num_nx[k];
				quo_s[k] <= quo_nx[k];
			end
			den_s[0]  <= req.den;
			side_s[0] <= req.side;
			for (int k = 1; k < N; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign rsp.valid = vld_s[N-1];
	assign rsp.quo   = quo_s[N-1];
	assign rsp.side  = side_s[N-1];

endmodule

// File: test/barometer_pressure_compensation_top_tb.sv
// Testbench for the barometer compensation block: predicted results checked against the output channel
module barometer_pressure_compensation_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 83;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [15:0] ut;
		logic [18:0] up;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic [19:0]        pres;
		logic               stat;
	} reading_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [15:0] raw_temperature = 0;
	logic [18:0] raw_pressure = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] temperature_tenths;
	logic [19:0] pressure_pa;
	logic status;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	barometer_pressure_compensation_top dut (.*);

	always #10 clk = ~clk;

	// calibration copy
	logic [31:0] k_ac12, k_ac34, k_ac56, k_b12, k_mcmd;
	logic [1:0] k_oss;

	sample_t pending_samples[$];
	reading_t expected_readings[$];
	int errors = 0;
	int cycles = 0;
	int sent = 0;
	bit long_hold = 0;
	int send_gap = 0;
	int recv_gap = 0;

	// truncating signed division of wrapping words
	function automatic logic [31:0] tdiv(logic [31:0] a, logic [31:0] d);
		if (d == 32'hFFFF_FFFF && a == 32'h8000_0000) return a;
		return 32'($signed(a) / $signed(d));
	endfunction

	function automatic reading_t compensate(sample_t s);
		reading_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, q, t;
		int signed ts, ps;
		ac1 = {{16{k_ac12[31]}}, k_ac12[31:16]};
		ac2 = {{16{k_ac12[15]}}, k_ac12[15:0]};
		ac3 = {{16{k_ac34[31]}}, k_ac34[31:16]};
		ac4 = {16'd0, k_ac34[15:0]};
		ac5 = {16'd0, k_ac56[31:16]};
		ac6 = {16'd0, k_ac56[15:0]};
		b1 = {{16{k_b12[31]}}, k_b12[31:16]};
		b2 = {{16{k_b12[15]}}, k_b12[15:0]};
		mc = {{16{k_mcmd[31]}}, k_mcmd[31:16]};
		md = {{16{k_mcmd[15]}}, k_mcmd[15:0]};
		r = '{temp: 0, pres: 0, stat: 1};
		// temperature
		x1 = tdiv(({16'd0, s.ut} - ac6) * ac5, 32768);
		den = x1 + md;
		if (den == 0) return r;
		x2 = tdiv(mc * 32'd2048, den);
		b5 = x1 + x2;
		t = tdiv(b5 + 32'd8, 16);
		// pressure
		b6 = b5 - 32'd4000;
		sq = tdiv(b6 * b6, 4096);
		x1 = tdiv(b2 * sq, 2048);
		x2 = tdiv(ac2 * b6, 2048);
		x3 = x1 + x2;
		b3 = tdiv(((ac1 * 32'd4 + x3) << k_oss) + 32'd2, 4);
		x1 = tdiv(ac3 * b6, 8192);
		x2 = tdiv(b1 * sq, 65536);
		x3 = tdiv(x1 + x2 + 32'd2, 4);
		b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
		if (b4 == 0) return r;
		b7 = ({13'd0, s.up} - b3) * (32'd50000 >> k_oss);
		if (!b7[31]) p = (b7 * 32'd2) / b4;
		else p = (b7 / b4) * 32'd2;
		q = tdiv(p, 256);
		x1 = tdiv((q * q) * 32'd3038, 65536);
		x2 = tdiv((32'd0 - 32'd7357) * p, 65536);
		p = p + tdiv(x1 + x2 + 32'd3791, 16);
		ts = $signed(t);
		if (ts < -32768) ts = -32768;
		if (ts > 32767) ts = 32767;
		ps = $signed(p);
		if (ps < 0) ps = 0;
		if (ps > 1048575) ps = 1048575;
		r.temp = ts[15:0];
		r.pres = ps[19:0];
		r.stat = 0;
		return r;
	endfunction

	function automatic int pick_gap();
		int c;
		c = $urandom_range(0, 99);
		if (c < 50) return 0;
		if (c < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver: offers queued items, predicts on acceptance
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_readings.push_back(compensate({raw_temperature, raw_pressure}));
				sent <= sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap == 0 && pending_samples.size() > 0) begin
					sample_t s;
					s = pending_samples.pop_front();
					in_valid <= 1;
					raw_temperature <= s.ut;
					raw_pressure <= s.up;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end
			end
		end
	end

	// monitor: random stalls, checks each reading
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t unexpected reading: got %0d %0d %0d", $realtime,
						temperature_tenths, pressure_pa, status);
					errors++;
				end else begin
					reading_t e;
					e = expected_readings.pop_front();
					if (e.temp !== temperature_tenths) begin
						$display("%0t temperature: expected %0d got %0d", $realtime,
							e.temp, temperature_tenths);
						errors++;
					end
					if (e.pres !== pressure_pa) begin
						$display("%0t pressure: expected %0d got %0d", $realtime,
							e.pres, pressure_pa);
						errors++;
					end
					if (e.stat !== status) begin
						$display("%0t status: expected %0d got %0d", $realtime,
							e.stat, status);
						errors++;
					end
				end
			end
			if (long_hold) out_ready <= 0;
			else if (recv_gap > 0) begin
				out_ready <= 0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1;
				recv_gap <= pick_gap();
			end
		end
	end

	// long receiver hold-off, counted in cycles
	task automatic hold_receiver(int n);
		long_hold = 1;
		repeat (n) @(posedge clk);
		long_hold = 0;
	endtask

	// checked at the falling edge, after every rising-edge update has settled
	task automatic wait_drained();
		while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			bpc_pkg::REG_AC1_AC2: k_ac12 = val;
			bpc_pkg::REG_AC3_AC4: k_ac34 = val;
			bpc_pkg::REG_AC5_AC6: k_ac56 = val;
			bpc_pkg::REG_B1_B2:   k_b12 = val;
			bpc_pkg::REG_MC_MD:   k_mcmd = val;
			bpc_pkg::REG_OSS:     k_oss = val[1:0];
			default: ;
		endcase
	endtask

	// typical datasheet calibration
	task automatic load_typical(logic [1:0] oss);
		write_reg(bpc_pkg::REG_AC1_AC2, {16'd408, 16'hFFC8});
		write_reg(bpc_pkg::REG_AC3_AC4, {16'hC6D1, 16'd32741});
		write_reg(bpc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
		write_reg(bpc_pkg::REG_B1_B2, {16'd6190, 16'd4});
		write_reg(bpc_pkg::REG_MC_MD, {16'hD4BD, 16'd2868});
		write_reg(bpc_pkg::REG_OSS, {30'd0, oss});
	endtask

	task automatic queue_random(int n, bit realistic);
		repeat (n) begin
			sample_t s;
			if (realistic && $urandom_range(0, 3) != 0) begin
				s.ut = $urandom_range(20000, 35000);
				s.up = $urandom_range(10000, 200000);
			end else begin
				s.ut = $urandom;
				s.up = $urandom;
			end
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		k_ac12 = 0; k_ac34 = 0; k_ac56 = 0; k_b12 = 0; k_mcmd = 0;
		k_oss = bpc_pkg::OSS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// reset calibration: temperature divisor is zero
		pending_samples.push_back('{16'd27898, 19'd23843});
		pending_samples.push_back('{16'hFFFF, 19'h7FFFF});
		wait_drained();

		// datasheet example at oss 0, then field extremes
		load_typical(2'd0);
		pending_samples.push_back('{16'd27898, 19'd23843});
		pending_samples.push_back('{16'd0, 19'd0});
		pending_samples.push_back('{16'hFFFF, 19'h7FFFF});
		pending_samples.push_back('{16'd0, 19'h7FFFF});
		pending_samples.push_back('{16'hFFFF, 19'd0});
		pending_samples.push_back('{16'h5555, 19'h2AAAA});
		pending_samples.push_back('{16'hAAAA, 19'h55555});
		wait_drained();

		// pressure divisor zero: AC4 = 0
		write_reg(bpc_pkg::REG_AC3_AC4, {16'hC6D1, 16'd0});
		pending_samples.push_back('{16'd27898, 19'd23843});
		// temperature divisor zero with AC5 = 0, MD = 0
		wait_drained();
		write_reg(bpc_pkg::REG_AC5_AC6, 32'd0);
		write_reg(bpc_pkg::REG_MC_MD, {16'hD4BD, 16'd0});
		pending_samples.push_back('{16'd1234, 19'd4321});
		wait_drained();

		// extreme coefficients, saturation both ways
		write_reg(bpc_pkg::REG_AC1_AC2, 32'h7FFF_8000);
		write_reg(bpc_pkg::REG_AC3_AC4, 32'h8000_FFFF);
		write_reg(bpc_pkg::REG_AC5_AC6, 32'hFFFF_0000);
		write_reg(bpc_pkg::REG_B1_B2, 32'h8000_7FFF);
		write_reg(bpc_pkg::REG_MC_MD, 32'h8000_0001);
		write_reg(bpc_pkg::REG_OSS, 32'd3);
		pending_samples.push_back('{16'd0, 19'd0});
		pending_samples.push_back('{16'hFFFF, 19'h7FFFF});
		pending_samples.push_back('{16'h8000, 19'h40000});
		wait_drained();

		// random phases over oversampling settings, the third with a long stall
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 4) load_typical(ph[1:0]);
			else begin
				write_reg(bpc_pkg::REG_AC1_AC2, $urandom);
				write_reg(bpc_pkg::REG_AC3_AC4, $urandom);
				write_reg(bpc_pkg::REG_AC5_AC6, $urandom);
				write_reg(bpc_pkg::REG_B1_B2, $urandom);
				write_reg(bpc_pkg::REG_MC_MD, $urandom);
				write_reg(bpc_pkg::REG_OSS, $urandom_range(0, 3));
			end
			queue_random(225, ph < 4);
			if (ph == 2) begin
				repeat (20) @(posedge clk);
				hold_receiver(300);
			end
			wait_drained();
		end

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end
endmodule
